// ===== rtl/tape_pulse_frame_encoder_top_assert.svh =====
// Assertion macros for the tape pulse frame encoder.
// Users supply clk and arst_n in the including scope.
`ifndef TAPE_PULSE_FRAME_ENCODER_TOP_ASSERT_SVH
`define TAPE_PULSE_FRAME_ENCODER_TOP_ASSERT_SVH

// property must hold at every clock edge out of reset
`define TPFE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tpfe assertion failed");

// expression must never be true out of reset
`define TPFE_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("tpfe forbidden condition seen");

`endif

// ===== rtl/tpfe_pkg.sv =====
// Package for the tape pulse frame encoder: payload, config and command types,
// mode and pulse kind codes, reset values. No dependencies.
`timescale 1ns / 1ps

package tpfe_pkg;

	localparam logic [2:0] MODE_DATA   = 3'd0;
	localparam logic [2:0] MODE_RAW    = 3'd1;
	localparam logic [2:0] MODE_CSUM   = 3'd2;
	localparam logic [2:0] MODE_LEADER = 3'd3;
	localparam logic [2:0] MODE_SINGLE = 3'd4;

	localparam logic [1:0] KIND_SHORT  = 2'd0;
	localparam logic [1:0] KIND_MEDIUM = 2'd1;
	localparam logic [1:0] KIND_LONG   = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] REG_INVERT = 2'd0;
	localparam logic [1:0] REG_SHORT  = 2'd1;
	localparam logic [1:0] REG_MEDIUM = 2'd2;
	localparam logic [1:0] REG_LONG   = 2'd3;

	localparam logic [15:0] SHORT_RST  = 16'd176;
	localparam logic [15:0] MEDIUM_RST = 16'd256;
	localparam logic [15:0] LONG_RST   = 16'd336;

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_MARK_LONG = 5'd0;
	localparam logic [STEP_W-1:0] STEP_MARK_MED  = 5'd1;
	localparam logic [STEP_W-1:0] STEP_BIT0      = 5'd2;
	localparam logic [STEP_W-1:0] STEP_PARITY    = 5'd18;
	localparam logic [STEP_W-1:0] STEP_FRAME_END = 5'd19;
	localparam logic [STEP_W-1:0] STEP_END_PULSE = 5'd20;

	localparam int DEF_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  data_byte;
		logic [1:0]  single_kind;
		logic [15:0] run_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  pulse_kind;
		logic [15:0] half_period_us;
		logic [16:0] repeat_count;
		logic        start_level;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic        invert_level;
		logic [15:0] short_half_us;
		logic [15:0] medium_half_us;
		logic [15:0] long_half_us;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_FRAMED     = 2'd0,
		OP_FRAMED_END = 2'd1,
		OP_PULSE      = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  value;
		logic [1:0]  kind;
		logic [16:0] count;
	} cmd_t;

endpackage

// ===== rtl/tpfe_front.sv =====
// Front end: accepts input items, classifies them into pulse commands and
// keeps the running checksum. Depends on tpfe_pkg.
`timescale 1ns / 1ps

module tpfe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tpfe_pkg::in_item_t in_data,
	input  logic             full,
	output logic             push,
	output tpfe_pkg::cmd_t   push_cmd
);
	import tpfe_pkg::*;

	logic [7:0] csum_q;
	logic       accept;
	logic       mode_ok;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && mode_ok;

	always_comb begin
		mode_ok        = 1'b1;
		push_cmd.op    = OP_PULSE;
		push_cmd.value = in_data.data_byte;
		push_cmd.kind  = KIND_SHORT;
		push_cmd.count = 17'd1;
		case (in_data.mode)
			MODE_DATA, MODE_RAW: begin
				push_cmd.op = OP_FRAMED;
			end
			MODE_CSUM: begin
				push_cmd.op    = OP_FRAMED_END;
				push_cmd.value = csum_q;
			end
			MODE_LEADER: begin
				push_cmd.count = {1'b0, in_data.run_length} + 17'd1;
			end
			MODE_SINGLE: begin
				push_cmd.kind = (in_data.single_kind == KIND_NONE) ? KIND_LONG
					: in_data.single_kind;
			end
			default: begin
				mode_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q <= 8'd0;
		end else if (accept) begin
			if (in_data.mode == MODE_DATA) begin
				csum_q <= csum_q ^ in_data.data_byte;
			end else if (in_data.mode == MODE_CSUM) begin
				csum_q <= 8'd0;
			end
		end
	end

endmodule

// ===== rtl/tpfe_queue.sv =====
// Command queue between front and back end, register based.
// Depends on tpfe_pkg.
`timescale 1ns / 1ps

module tpfe_queue #(
	parameter int DEPTH = tpfe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tpfe_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output tpfe_pkg::cmd_t head
);
	import tpfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tpfe_back.sv =====
// Back end: steps the head command into the output register, one pulse per cycle
// unless the receiver stalls. Depends on tpfe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tape_pulse_frame_encoder_top_assert.svh"

module tpfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tpfe_pkg::cfg_t      cfg,
	input  logic                cmd_valid,
	input  tpfe_pkg::cmd_t      cmd,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output tpfe_pkg::out_item_t out_data
);
	import tpfe_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] sub;
	logic              out_valid_q;
	out_item_t         out_data_q;
	out_item_t         nxt;
	logic              advance;
	logic              is_last;
	logic              bit_val;
	logic [1:0]        kind;

	assign sub     = step_q - STEP_BIT0;
	assign advance = cmd_valid && (!out_valid_q || out_ready);
	assign pop     = advance && is_last;

	always_comb begin
		bit_val = (step_q >= STEP_PARITY) ? ~^cmd.value : cmd.value[sub[3:1]];
		kind    = (bit_val ^ sub[0]) ? KIND_MEDIUM : KIND_SHORT;
		is_last = 1'b0;
		case (cmd.op)
			OP_PULSE: begin
				kind    = cmd.kind;
				is_last = 1'b1;
			end
			OP_FRAMED, OP_FRAMED_END: begin
				if (step_q == STEP_MARK_LONG || step_q == STEP_END_PULSE) begin
					kind = KIND_LONG;
				end else if (step_q == STEP_MARK_MED) begin
					kind = KIND_MEDIUM;
				end
				is_last = (cmd.op == OP_FRAMED) ? (step_q == STEP_FRAME_END)
					: (step_q == STEP_END_PULSE);
			end
			default: begin
				is_last = 1'b1;
			end
		endcase
	end

	always_comb begin
		nxt.pulse_kind   = kind;
		nxt.repeat_count = (cmd.op == OP_PULSE) ? cmd.count : 17'd1;
		nxt.start_level  = cfg.invert_level;
		nxt.last         = is_last;
		case (kind)
			KIND_SHORT:  nxt.half_period_us = cfg.short_half_us;
			KIND_MEDIUM: nxt.half_period_us = cfg.medium_half_us;
			default:     nxt.half_period_us = cfg.long_half_us;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q <= '0;
			end else if (advance) begin
				step_q <= step_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`TPFE_ASSERT_NEVER(a_step_range, step_q > STEP_END_PULSE)
	`TPFE_ASSERT(a_mid_frame_held, (step_q != '0) |-> cmd_valid)
	`TPFE_ASSERT(a_single_count,
		(out_valid_q && out_data_q.pulse_kind != KIND_SHORT) |-> (out_data_q.repeat_count == 17'd1))
	`TPFE_ASSERT(a_pop_marks_last, pop |=> (out_valid_q && out_data_q.last))

endmodule

// ===== rtl/tape_pulse_frame_encoder_top.sv =====
// Top level of the tape pulse frame encoder: APB config registers, front end,
// command queue, back end. Depends on tpfe_pkg, tpfe_front, tpfe_queue, tpfe_back.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one framing request per transfer:
//   mode 0 data byte, 1 raw byte, 2 checksum and end pulse, 3 leader, 4 single pulse.
//   Modes 5 to 7 are taken and dropped. out channel (out_valid/out_ready/out_data)
//   gives one pulse symbol per transfer; last marks the final symbol of a request.
//   A request goes into the queue, its symbols then into the output register.
//   The back end sequencer emits one symbol per cycle unless the receiver
//   stalls; a request gives 20 symbols (modes 0, 1), 21 (mode 2) or 1 (3, 4).
//   The front end keeps taking requests into a QUEUE_DEPTH entry queue meanwhile.
//   Reset: checksum cleared, queue empty, registers at 0/176/256/336 us.
//   Receiver stall: the output register holds its symbol, the sequencer waits,
//   and in_ready drops once the queue is full.
//   Registers (APB, 4 byte stride): invert_level, short, medium, long half period.
//   Write registers only while the block is idle.
`timescale 1ns / 1ps

module tape_pulse_frame_encoder_top #(
	parameter int QUEUE_DEPTH = tpfe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  tpfe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tpfe_pkg::out_item_t out_data
);
	import tpfe_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;
	logic       full;
	logic       push;
	cmd_t       push_cmd;
	logic       pop;
	logic       head_valid;
	cmd_t       head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_level   <= 1'b0;
			cfg_q.short_half_us  <= SHORT_RST;
			cfg_q.medium_half_us <= MEDIUM_RST;
			cfg_q.long_half_us   <= LONG_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_INVERT: cfg_q.invert_level   <= pwdata[0];
				REG_SHORT:  cfg_q.short_half_us  <= pwdata[15:0];
				REG_MEDIUM: cfg_q.medium_half_us <= pwdata[15:0];
				REG_LONG:   cfg_q.long_half_us   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INVERT: prdata = {31'd0, cfg_q.invert_level};
			REG_SHORT:  prdata = {16'd0, cfg_q.short_half_us};
			REG_MEDIUM: prdata = {16'd0, cfg_q.medium_half_us};
			REG_LONG:   prdata = {16'd0, cfg_q.long_half_us};
			default:    prdata = 32'd0;
		endcase
	end

	tpfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	tpfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tpfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (head_valid),
		.cmd       (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
